FILE: src/riu_pkg.sv
// Shared constants and the ring-code function for the 3x3 texture-code stream.
// No dependencies; imported by lbp_riu2_3x3_stream.
`default_nettype none
package riu_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 12;
    localparam int DIM_BITS   = 12;
    localparam int CODE_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_COMPARE = 2'd2;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [DIM_BITS-1:0] DIM_MIN      = 12'd3;
    localparam logic [DIM_BITS-1:0] WIDTH_MAX    = DIM_BITS'(MAX_WIDTH);

    localparam logic [CODE_BITS-1:0] CODE_NON_UNIFORM = 4'd9;

    // Count of set bits if the circular pattern has at most two transitions,
    // else the non-uniform code.
    function automatic logic [CODE_BITS-1:0] ring_code(input logic [7:0] pat);
        logic [7:0] rot;
        logic [7:0] diff;
        logic [3:0] trans;
        logic [3:0] ones;
        rot   = {pat[6:0], pat[7]};
        diff  = pat ^ rot;
        trans = '0;
        ones  = '0;
        for (int i = 0; i < 8; i++) begin
            trans = trans + 4'(diff[i]);
            ones  = ones + 4'(pat[i]);
        end
        return (trans <= 4'd2) ? ones : CODE_NON_UNIFORM;
    endfunction

endpackage
`default_nettype wire

FILE: src/lbp_riu2_3x3_stream.sv
// A result is held in the stage 1 registers, then in the output register.
// One pixel per cycle unless stalled; one line memory read and one write per cycle.
// The window shifts in the read stage, using the memory read issued at take-in.
// Reset (aresetn low, synchronous): counters, window, valids and configuration registers to defaults.
// The line memory is not cleared; the first two rows of a frame fill it before use.
// Depends on riu_pkg.
`default_nettype none
module lbp_riu2_3x3_stream (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [riu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [riu_pkg::DIM_BITS-1:0]       cfg_data,
    // pixel input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,   // [15:0] pixel
    // code output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [3:0] code, [7:4] zero
    output logic                                    m_tlast
);
    import riu_pkg::*;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    // configuration registers
    logic [DIM_BITS-1:0] width_reg, height_reg;
    logic                signed_reg;

    // stage 0 counters
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    // stage 1 (memory read stage)
    logic                p1_valid_reg;
    pix_t                p1_pix_reg;
    logic [COL_BITS-1:0] p1_col_reg;
    logic                p1_emit_reg, p1_last_reg;

    // window and line memory
    pix_t                win_reg [6];
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] rd_data_reg;

    // output register
    logic                 out_valid_reg;
    logic [CODE_BITS-1:0] out_code_reg;
    logic                 out_last_reg;

    logic in_fire, p1_fire, out_free;
    logic [DIM_BITS-1:0] w_eff, h_eff;
    logic row_end, frame_end, emit;
    pix_t top, mid, bot, flip;
    logic [7:0] pat;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            signed_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                CFG_SIGNED_COMPARE: signed_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshakes: stage 1 moves on unless its result is blocked
    assign out_free = !out_valid_reg || m_tready;
    assign p1_fire  = p1_valid_reg && (!p1_emit_reg || out_free);
    assign s_tready = !p1_valid_reg || p1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // stage 0: frame position, end flags
    always_comb begin
        w_eff = width_reg;
        if (width_reg < DIM_MIN) w_eff = DIM_MIN;
        if (width_reg > WIDTH_MAX) w_eff = WIDTH_MAX;
        h_eff = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;

        row_end   = ({1'b0, col_reg} + 12'd1) >= w_eff;
        frame_end = row_end && (({1'b0, row_reg} + 13'd1) >= {1'b0, h_eff});
        emit      = (row_reg >= ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));

        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROW_BITS'(1);
        end else begin
            col_next = col_reg + COL_BITS'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_fire) p1_valid_reg <= 1'b1;
            else if (p1_fire) p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p1_pix_reg  <= s_tdata[PIXEL_BITS-1:0];
            p1_col_reg  <= col_reg;
            p1_emit_reg <= emit;
            p1_last_reg <= frame_end;
        end
    end

    // line memory: read at take-in, write back the shifted column in stage 1.
    // Consecutive items always address different columns, so no forwarding.
    always_ff @(posedge aclk) begin
        if (in_fire) rd_data_reg <= line_mem[col_reg];
        if (p1_fire) line_mem[p1_col_reg] <= {mid, bot};
    end

    // stage 1: neighbour compare, sign handled by flipping the top bit
    always_comb begin
        top  = rd_data_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        mid  = rd_data_reg[PIXEL_BITS-1:0];
        bot  = p1_pix_reg;
        flip = {signed_reg, {(PIXEL_BITS-1){1'b0}}};
        pat[7] = (win_reg[0] ^ flip) >= (win_reg[4] ^ flip);
        pat[6] = (win_reg[3] ^ flip) >= (win_reg[4] ^ flip);
        pat[5] = (top        ^ flip) >= (win_reg[4] ^ flip);
        pat[4] = (mid        ^ flip) >= (win_reg[4] ^ flip);
        pat[3] = (bot        ^ flip) >= (win_reg[4] ^ flip);
        pat[2] = (win_reg[5] ^ flip) >= (win_reg[4] ^ flip);
        pat[1] = (win_reg[2] ^ flip) >= (win_reg[4] ^ flip);
        pat[0] = (win_reg[1] ^ flip) >= (win_reg[4] ^ flip);
    end

    // window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else if (p1_fire) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_fire && p1_emit_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_fire && p1_emit_reg) begin
            out_code_reg <= ring_code(pat);
            out_last_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_code_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
